@@ rtl/sha256_byte_stream_digest_assert.svh @@
// Assertion macros for the SHA-256 byte stream digest block.
// Included by rtl/sha256_byte_stream_digest.sv; no other dependencies.
`ifndef SHA256_BYTE_STREAM_DIGEST_ASSERT_SVH
`define SHA256_BYTE_STREAM_DIGEST_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sha_pkg.sv @@
// Package for the SHA-256 byte stream digest block: round constants,
// initial vector, sequencer states and round helper functions. No dependencies.
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_EMIT
  } state_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[i];
  endfunction

  function automatic logic [31:0] init_vec(input logic [2:0] i);
    logic [31:0] v [8];
    v = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return v[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/sha256_byte_stream_digest.sv @@
// SHA-256 digest of a byte stream; one shared round unit under a sequencer.
// Depends on sha_pkg and sha256_byte_stream_digest_assert.svh.
//
//  channel | direction | signals
//  in      | sink      | in_valid/in_ready, data_byte, byte_present, message_end
//  out     | source    | out_valid/out_ready, digest_word, word_number, final_word
//
// A byte that does not fill a block is written while the sequencer stays idle. A full
// block keeps the input busy through the load, round and add states (one shared round unit).
// A message end pads 1 byte per cycle up to the block end (mark, zeros, length),
// then compresses; a mark at byte 56 or later costs a second pad and compress.
// Eight digest words follow, one per accepted output request.
// Synchronous reset loads the initial vector; no clearing pass is needed.
// The input is not ready while a block is padded, compressed or the digest drains.
module sha256_byte_stream_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        final_word
);

  `include "sha256_byte_stream_digest_assert.svh"

  sha_pkg::state_t state, state_next;

  logic [31:0] block_words [16];   // block buffer as big-endian words
  logic [31:0] sched [16];         // rolling schedule
  logic [31:0] hash_words [8];
  logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
  logic [5:0]  fill_count;
  logic [63:0] byte_total;
  logic [5:0]  round_cnt;
  logic        ending;             // message end pending
  logic        mark_done;          // pad mark already written
  logic        len_block;          // current pad block carries the length
  logic        len_done;           // length block handed to compression
  logic [2:0]  emit_cnt;

  logic        accept;
  logic [31:0] w_cur, t1, t2, w15, w2, s0, s1;
  logic [63:0] bits;

  logic        cur_len_block;
  logic [5:0]  len_sel;
  logic [7:0]  pad_byte;
  logic        bwr;
  logic [7:0]  bval;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == sha_pkg::ST_IDLE);
  assign bits     = {byte_total[60:0], 3'b000};

  // Schedule word and round arithmetic for the shared round unit
  always_comb begin
    w15 = sched[1];
    w2  = sched[14];
    s0  = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
    s1  = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
    if (round_cnt < 6'd16) begin
      w_cur = sched[0];
    end else begin
      w_cur = sched[0] + s0 + sched[9] + s1;
    end
    t1 = vh + (sha_pkg::rotr(ve, 6) ^ sha_pkg::rotr(ve, 11) ^ sha_pkg::rotr(ve, 25))
       + ((ve & vf) ^ (~ve & vg)) + sha_pkg::round_k(round_cnt) + w_cur;
    t2 = (sha_pkg::rotr(va, 2) ^ sha_pkg::rotr(va, 13) ^ sha_pkg::rotr(va, 22))
       + ((va & vb) ^ (va & vc) ^ (vb & vc));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sha_pkg::ST_IDLE: begin
        if (accept) begin
          if (byte_present && fill_count == 6'd63) begin
            state_next = sha_pkg::ST_LOAD;
          end else if (message_end) begin
            state_next = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_LOAD: begin
        if (round_cnt == 6'd15) state_next = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: begin
        if (round_cnt == 6'd63) state_next = sha_pkg::ST_ADD;
      end
      sha_pkg::ST_ADD: begin
        if (!ending) state_next = sha_pkg::ST_IDLE;
        else if (len_done) state_next = sha_pkg::ST_EMIT;
        else state_next = sha_pkg::ST_PAD;
      end
      sha_pkg::ST_PAD: begin
        if (fill_count == 6'd63) state_next = sha_pkg::ST_LOAD;
      end
      sha_pkg::ST_EMIT: begin
        if (out_ready && emit_cnt == 3'd7) state_next = sha_pkg::ST_IDLE;
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= sha_pkg::ST_IDLE;
    else state <= state_next;
  end

  // Pad byte: mark first, then zeros, length bytes at the end of the length block
  always_comb begin
    cur_len_block = mark_done ? len_block : (fill_count < sha_pkg::LEN_POS);
    len_sel       = 6'd63 - fill_count;
    if (!mark_done) begin
      pad_byte = sha_pkg::PAD_MARK;
    end else if (cur_len_block && fill_count >= sha_pkg::LEN_POS) begin
      pad_byte = bits[{len_sel[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Byte write into the block buffer (shared by input and padding)
  always_comb begin
    bwr  = 1'b0;
    bval = data_byte;
    if (state == sha_pkg::ST_IDLE && accept && byte_present) begin
      bwr = 1'b1;
    end else if (state == sha_pkg::ST_PAD) begin
      bwr  = 1'b1;
      bval = pad_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (bwr) begin
      block_words[fill_count[5:2]][{~fill_count[1:0], 3'b000} +: 8] <= bval;
    end
  end

  // Schedule, counters and round variables
  always_ff @(posedge clk) begin
    if (state == sha_pkg::ST_LOAD) begin
      for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
      sched[15] <= block_words[round_cnt[3:0]];
    end else if (state == sha_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
      sched[15] <= w_cur;
      vh <= vg; vg <= vf; vf <= ve; ve <= vd + t1;
      vd <= vc; vc <= vb; vb <= va; va <= t1 + t2;
    end
    if (state == sha_pkg::ST_LOAD && round_cnt == 6'd0) begin
      va <= hash_words[0]; vb <= hash_words[1];
      vc <= hash_words[2]; vd <= hash_words[3];
      ve <= hash_words[4]; vf <= hash_words[5];
      vg <= hash_words[6]; vh <= hash_words[7];
    end
    if (rst) begin
      fill_count <= '0;
      byte_total <= '0;
      round_cnt  <= '0;
      ending     <= 1'b0;
      mark_done  <= 1'b0;
      len_block  <= 1'b0;
      len_done   <= 1'b0;
      emit_cnt   <= '0;
      for (int i = 0; i < 8; i++) hash_words[i] <= sha_pkg::init_vec(3'(i));
    end else begin
      unique case (state)
        sha_pkg::ST_IDLE: begin
          if (accept) begin
            ending    <= message_end;
            mark_done <= 1'b0;
            len_block <= 1'b0;
            len_done  <= 1'b0;
            if (byte_present) begin
              fill_count <= fill_count + 6'd1;
              byte_total <= byte_total + 64'd1;
            end
          end
        end
        sha_pkg::ST_LOAD: begin
          round_cnt <= (round_cnt == 6'd15) ? 6'd0 : round_cnt + 6'd1;
        end
        sha_pkg::ST_ROUND: begin
          round_cnt <= round_cnt + 6'd1;
        end
        sha_pkg::ST_ADD: begin
          hash_words[0] <= hash_words[0] + va; hash_words[1] <= hash_words[1] + vb;
          hash_words[2] <= hash_words[2] + vc; hash_words[3] <= hash_words[3] + vd;
          hash_words[4] <= hash_words[4] + ve; hash_words[5] <= hash_words[5] + vf;
          hash_words[6] <= hash_words[6] + vg; hash_words[7] <= hash_words[7] + vh;
          // Length did not fit: the next pad block carries it
          if (ending && !len_done) len_block <= 1'b1;
        end
        sha_pkg::ST_PAD: begin
          fill_count <= fill_count + 6'd1;
          mark_done  <= 1'b1;
          len_block  <= cur_len_block;
          if (fill_count == 6'd63) len_done <= cur_len_block;
        end
        sha_pkg::ST_EMIT: begin
          if (out_ready) begin
            emit_cnt <= emit_cnt + 3'd1;
            if (emit_cnt == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_words[i] <= sha_pkg::init_vec(3'(i));
              fill_count <= '0;
              byte_total <= '0;
              ending     <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output channel
  assign out_valid   = (state == sha_pkg::ST_EMIT);
  assign digest_word = hash_words[emit_cnt];
  assign word_number = emit_cnt;
  assign final_word  = (emit_cnt == 3'd7);

  `SHA_ASSERT_IMP(a_out_idle, clk, rst, out_valid, !in_ready, "output while input open")
  `SHA_ASSERT_IMP(a_round_range, clk, rst, state == sha_pkg::ST_LOAD, round_cnt < 6'd16, "load count out of range")
  `SHA_ASSERT_NEXT(a_emit_done, clk, rst, out_valid && out_ready && final_word, state == sha_pkg::ST_IDLE, "digest drain did not end")

endmodule

@@ dv/sha256_byte_stream_digest_tb.sv @@
// Self-checking testbench for the SHA-256 byte stream digest block.
// Depends on rtl/sha_pkg.sv and rtl/sha256_byte_stream_digest.sv.
module sha256_byte_stream_digest_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  num;
    logic        fin;
  } digest_req_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        message_end;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;

  sha256_byte_stream_digest dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .byte_present(byte_present), .message_end(message_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_number(word_number), .final_word(final_word)
  );

  byte_req_t   pending_bytes[$];
  digest_req_t expected_words[$];
  int          mismatch_count;
  bit          in_quiet;
  bit          out_quiet;
  bit          hold_go;
  bit          hold_used;
  int          hold_off_cycles;

  // Predictor state
  logic [31:0] chain[8];
  logic [7:0]  blk[64];
  logic [5:0]  fill;
  logic [63:0] total_bytes;

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] w[16];
    logic [31:0] v[8];
    logic [31:0] wi, t1, t2, w15, w2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        wi = w[i];
      end else begin
        w15 = w[(i - 15) & 15];
        w2 = w[(i - 2) & 15];
        wi = w[i & 15] + (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3)) + w[(i - 7) & 15]
             + (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10));
        w[i & 15] = wi;
      end
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(i[5:0]) + wi;
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic reset_chain();
    for (int i = 0; i < 8; i++) chain[i] = sha_pkg::init_vec(i[2:0]);
    fill = '0;
    total_bytes = '0;
  endtask

  // Advance the predictor by one accepted request
  task automatic predict_digest(byte_req_t r);
    int pos;
    logic [63:0] bits;
    digest_req_t d;
    if (r.present) begin
      blk[fill] = r.data;
      total_bytes++;
      fill++;
      if (fill == 0) compress_blk();
    end
    if (r.last) begin
      bits = total_bytes << 3;
      pos = fill;
      blk[pos] = sha_pkg::PAD_MARK;
      pos++;
      if (pos > 56) begin
        for (int i = pos; i < 64; i++) blk[i] = 8'h00;
        compress_blk();
        pos = 0;
      end
      for (int i = pos; i < 56; i++) blk[i] = 8'h00;
      for (int i = 0; i < 8; i++) blk[63 - i] = bits[8*i +: 8];
      compress_blk();
      for (int i = 0; i < 8; i++) begin
        d.word = chain[i];
        d.num = i[2:0];
        d.fin = (i == 7);
        expected_words.push_back(d);
      end
      reset_chain();
    end
  endtask

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Driver: present pending requests, hold until accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_digest({data_byte, byte_present, message_end});
      if (pending_bytes.size() > 0 && (in_quiet || $urandom_range(99) >= 19)) begin
        byte_req_t r;
        r = pending_bytes.pop_front();
        in_valid <= 1'b1;
        data_byte <= r.data;
        byte_present <= r.present;
        message_end <= r.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver ready with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_off_cycles <= 0;
      hold_used <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_off_cycles <= 600;
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= out_quiet || ($urandom_range(99) >= 19);
    end
  end

  // Monitor: compare each accepted digest word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected digest word %h num %0d", digest_word, word_number);
      end else begin
        digest_req_t e;
        e = expected_words.pop_front();
        if (e != {digest_word, word_number, final_word}) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("digest mismatch exp %h/%0d/%b got %h/%0d/%b", e.word, e.num, e.fin,
                     digest_word, word_number, final_word);
        end
      end
    end
  end

  task automatic queue_message(int len, int mode, bit force_end);
    byte_req_t r;
    for (int i = 0; i < len; i++) begin
      r.present = 1'b1;
      r.data = (mode == 0) ? 8'h00 : (mode == 1) ? 8'hff : 8'($urandom);
      r.last = (i == len - 1) && (force_end || $urandom_range(1) == 1);
      pending_bytes.push_back(r);
      if (r.last) return;
    end
    r.data = 8'($urandom);
    r.present = 1'b0;
    r.last = 1'b1;
    pending_bytes.push_back(r);
  endtask

  // Stimulus
  initial begin
    byte_req_t r;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    byte_present = 1'b0;
    message_end = 1'b0;
    mismatch_count = 0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    hold_go = 1'b0;
    reset_chain();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // Directed: empty message, byte with end, full block then two-block padding
    r = '{data: 8'h5a, present: 1'b0, last: 1'b0};
    pending_bytes.push_back(r);
    r = '{data: 8'h5a, present: 1'b0, last: 1'b1};
    pending_bytes.push_back(r);
    r = '{data: 8'h61, present: 1'b1, last: 1'b1};
    pending_bytes.push_back(r);
    queue_message(120, 2, 1'b1);
    // Short random messages
    for (int m = 0; m < 3; m++) begin
      queue_message(int'($urandom_range(4)), 2, 1'b0);
    end
    // Quiet stretch, then one long receiver hold-off
    wait (pending_bytes.size() <= 100);
    in_quiet = 1'b1;
    out_quiet = 1'b1;
    wait (pending_bytes.size() <= 60);
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    hold_go = 1'b1;
    wait (pending_bytes.size() == 0 && !in_valid);
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end
endmodule
